FILE: rtl/dgcd_pkg.sv
package dgcd_pkg;

    // Fixed field widths of the streaming payload and the configuration register.
    localparam int OP_W           = 2;
    localparam int VERTEX_FIELD_W = 6;
    localparam int COUNT_FIELD_W  = 7;

    // Common width for comparing the vertex count against field values and the size.
    localparam int WIDE_W = 8;

    // Default number of vertices the stores are built for.
    localparam int DEF_VERTICES = 64;

    // Vertex count after reset.
    localparam logic [COUNT_FIELD_W-1:0] VCOUNT_RESET = COUNT_FIELD_W'(64);

    // Operation codes carried in s_tuser.
    typedef enum logic [OP_W-1:0] {
        OP_ADD_EDGE    = 2'd0,
        OP_CLEAR_EDGES = 2'd1,
        OP_CHECK       = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    // Search marks held per vertex.
    typedef enum logic [1:0] {
        MARK_NEW  = 2'd0,
        MARK_PATH = 2'd1,
        MARK_DONE = 2'd2
    } mark_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_edge;
        logic clear_edges;
        logic check_init;
        logic rd_start_mark;
        logic next_start;
        logic push_start;
        logic cursor_inc;
        logic take_edge;
        logic push_cand;
        logic pop;
        logic load_parent;
        logic result_load;
        logic res_bit;
    } cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic start_end;
        logic cursor_end;
        logic row_bit;
        logic mark_path;
        logic mark_new;
        logic last_frame;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/dgcd_ctrl.sv
module dgcd_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dgcd_pkg::OP_W-1:0]  s_op,
    output dgcd_pkg::cmd_t             cmd,
    input  dgcd_pkg::sts_t             sts
);
    import dgcd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_START_W,
        ST_SCAN,
        ST_MARK_W,
        ST_PARENT,
        ST_RES
    } state_t;

    state_t state_reg, state_next;
    logic   res_reg, res_next;

    // New transactions are taken only between searches.
    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_op)
                        OP_ADD_EDGE:    cmd.add_edge = 1'b1;
                        OP_CLEAR_EDGES: cmd.clear_edges = 1'b1;
                        OP_CHECK: begin
                            cmd.check_init = 1'b1;
                            state_next     = ST_START;
                        end
                        default: ;
                    endcase
                end
            end
            ST_START: begin
                if (sts.start_end) begin
                    res_next   = 1'b0;
                    state_next = ST_RES;
                end else begin
                    cmd.rd_start_mark = 1'b1;
                    state_next        = ST_START_W;
                end
            end
            ST_START_W: begin
                if (sts.mark_new) begin
                    cmd.push_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    cmd.next_start = 1'b1;
                    state_next     = ST_START;
                end
            end
            ST_SCAN: begin
                if (sts.cursor_end) begin
                    cmd.pop = 1'b1;
                    if (sts.last_frame) begin
                        cmd.next_start = 1'b1;
                        state_next     = ST_START;
                    end else begin
                        state_next = ST_PARENT;
                    end
                end else if (!sts.row_bit) begin
                    cmd.cursor_inc = 1'b1;
                end else begin
                    cmd.take_edge = 1'b1;
                    state_next    = ST_MARK_W;
                end
            end
            ST_MARK_W: begin
                if (sts.mark_path) begin
                    res_next   = 1'b1;
                    state_next = ST_RES;
                end else if (sts.mark_new) begin
                    cmd.push_cand = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_PARENT: begin
                cmd.load_parent = 1'b1;
                state_next      = ST_SCAN;
            end
            ST_RES: begin
                if (sts.out_free) begin
                    cmd.result_load = 1'b1;
                    cmd.res_bit     = res_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and result bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            res_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

FILE: rtl/dgcd_datapath.sv
module dgcd_datapath #(
    parameter int VERTICES = dgcd_pkg::DEF_VERTICES
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [dgcd_pkg::COUNT_FIELD_W-1:0]    cfg_wr_data,
    input  logic [dgcd_pkg::VERTEX_FIELD_W-1:0]   in_from,
    input  logic [dgcd_pkg::VERTEX_FIELD_W-1:0]   in_to,
    input  dgcd_pkg::cmd_t                        cmd,
    output dgcd_pkg::sts_t                        sts,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic                                  m_has_cycle
);
    import dgcd_pkg::*;

    localparam int VW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES + 1);
    localparam int SW = VW + CW;
    localparam logic [WIDE_W-1:0] VMAX      = WIDE_W'(VERTICES);
    localparam logic [CW-1:0]     DEPTH_MAX = CW'(VERTICES);

    // Configuration and search counters.
    logic [COUNT_FIELD_W-1:0] vcount_reg;
    logic [CW-1:0]            start_reg;
    logic [CW-1:0]            depth_reg;
    logic [CW-1:0]            cursor_reg;
    logic [VW-1:0]            top_reg;
    logic [VW-1:0]            cand_reg;

    // Adjacency store, one row per source vertex.
    logic [VERTICES-1:0] adj_mem [VERTICES];
    logic [VERTICES-1:0] row_valid_reg;
    logic [VERTICES-1:0] row_reg;
    logic                row_ok_reg;

    // Vertex marks.
    logic [1:0]          mark_mem [VERTICES];
    logic [VERTICES-1:0] mark_valid_reg;
    logic [1:0]          mark_rd_reg;
    logic                mark_ok_reg;

    // Frames below the top of the path: vertex over neighbour cursor.
    logic [SW-1:0] stack_mem [VERTICES];
    logic [SW-1:0] stack_rd_reg;

    // Result register.
    logic m_valid_reg;
    logic m_data_reg;

    logic [WIDE_W-1:0] vc_ext, n_wide;
    logic [CW-1:0]     n_cnt;
    logic              edge_ok;
    logic [VW-1:0]     from_idx, to_idx, start_idx, cursor_idx;
    logic [CW-1:0]     depth_m1, depth_m2;
    logic [VW-1:0]     stack_vtx;
    logic [CW-1:0]     stack_cur;
    logic [1:0]        mark_eff;
    logic              mark_we, mark_re, adj_re;
    logic [VW-1:0]     mark_waddr, mark_raddr, adj_raddr;
    logic [1:0]        mark_wdata;

    // Active vertex count, saturated at the store size.
    assign vc_ext  = WIDE_W'(vcount_reg);
    assign n_wide  = (vc_ext > VMAX) ? VMAX : vc_ext;
    assign n_cnt   = CW'(n_wide);
    assign edge_ok = (WIDE_W'(in_from) < n_wide) && (WIDE_W'(in_to) < n_wide);

    assign from_idx   = VW'(in_from);
    assign to_idx     = VW'(in_to);
    assign start_idx  = start_reg[VW-1:0];
    assign cursor_idx = cursor_reg[VW-1:0];
    assign depth_m1   = depth_reg - CW'(1);
    assign depth_m2   = depth_reg - CW'(2);
    assign stack_vtx  = stack_rd_reg[SW-1:CW];
    assign stack_cur  = stack_rd_reg[CW-1:0];
    assign mark_eff   = mark_ok_reg ? mark_rd_reg : MARK_NEW;

    // Mark and adjacency port addressing.
    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = start_idx;
        mark_wdata = MARK_PATH;
        if (cmd.push_start) begin
            mark_we = 1'b1;
        end else if (cmd.push_cand) begin
            mark_we    = 1'b1;
            mark_waddr = cand_reg;
        end else if (cmd.pop) begin
            mark_we    = 1'b1;
            mark_waddr = top_reg;
            mark_wdata = MARK_DONE;
        end

        mark_re    = cmd.rd_start_mark || cmd.take_edge;
        mark_raddr = cmd.take_edge ? cursor_idx : start_idx;

        adj_re    = cmd.push_start || cmd.push_cand || cmd.load_parent;
        adj_raddr = start_idx;
        if (cmd.push_cand) begin
            adj_raddr = cand_reg;
        end else if (cmd.load_parent) begin
            adj_raddr = stack_vtx;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else if (cfg_wr_en) begin
            vcount_reg <= cfg_wr_data;
        end
    end

    // Start vertex and stack depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            depth_reg <= '0;
        end else begin
            if (cmd.check_init) begin
                start_reg <= '0;
                depth_reg <= '0;
            end
            if (cmd.next_start) begin
                start_reg <= start_reg + CW'(1);
            end
            if (cmd.push_start) begin
                depth_reg <= CW'(1);
            end
            if (cmd.push_cand) begin
                depth_reg <= depth_reg + CW'(1);
            end
            if (cmd.pop) begin
                depth_reg <= depth_m1;
            end
        end
    end

    // Top frame: vertex, neighbour cursor and the neighbour under test.
    always_ff @(posedge aclk) begin
        if (cmd.push_start) begin
            top_reg    <= start_idx;
            cursor_reg <= '0;
        end
        if (cmd.cursor_inc) begin
            cursor_reg <= cursor_reg + CW'(1);
        end
        if (cmd.take_edge) begin
            cand_reg   <= cursor_idx;
            cursor_reg <= cursor_reg + CW'(1);
        end
        if (cmd.push_cand) begin
            top_reg    <= cand_reg;
            cursor_reg <= '0;
        end
        if (cmd.load_parent) begin
            top_reg    <= stack_vtx;
            cursor_reg <= stack_cur;
        end
    end

    // Frame stack: the old top is saved on a push, the parent is read on a pop.
    always_ff @(posedge aclk) begin
        if (cmd.push_cand) begin
            stack_mem[depth_m1[VW-1:0]] <= {top_reg, cursor_reg};
        end
        if (cmd.pop && !sts.last_frame) begin
            stack_rd_reg <= stack_mem[depth_m2[VW-1:0]];
        end
    end

    // Row valid bits: a row that was never written since a clear reads as empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.clear_edges) begin
            row_valid_reg <= '0;
        end else if (cmd.add_edge && edge_ok) begin
            row_valid_reg[from_idx] <= 1'b1;
        end
    end

    // Adjacency memory with a bit write and a registered row read.
    always_ff @(posedge aclk) begin
        if (cmd.add_edge && edge_ok) begin
            if (row_valid_reg[from_idx]) begin
                adj_mem[from_idx][to_idx] <= 1'b1;
            end else begin
                adj_mem[from_idx] <= VERTICES'(1) << to_idx;
            end
        end
        if (adj_re) begin
            row_reg    <= adj_mem[adj_raddr];
            row_ok_reg <= row_valid_reg[adj_raddr];
        end
    end

    // Mark valid bits, all dropped at the start of a check.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_valid_reg <= '0;
        end else if (cmd.check_init) begin
            mark_valid_reg <= '0;
        end else if (mark_we) begin
            mark_valid_reg[mark_waddr] <= 1'b1;
        end
    end

    // Mark memory with a registered read.
    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (mark_re) begin
            mark_rd_reg <= mark_mem[mark_raddr];
            mark_ok_reg <= mark_valid_reg[mark_raddr];
        end
    end

    // Result register towards the master side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_data_reg <= cmd.res_bit;
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign m_has_cycle = m_data_reg;

    // Status back to the controller.
    assign sts.start_end  = (start_reg >= n_cnt);
    assign sts.cursor_end = (cursor_reg >= n_cnt);
    assign sts.row_bit    = row_ok_reg & row_reg[cursor_idx];
    assign sts.mark_path  = (mark_eff == MARK_PATH);
    assign sts.mark_new   = (mark_eff == MARK_NEW);
    assign sts.last_frame = (depth_reg == CW'(1));
    assign sts.out_free   = !m_valid_reg || m_tready;

    // A push never overruns the stack, a pop never underruns it, and a result
    // never overwrites one that is still waiting.
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_cand |-> (depth_reg < DEPTH_MAX))
        else $error("frame stack overrun on push");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (depth_reg != '0))
        else $error("pop from an empty frame stack");

    a_result_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !cmd.result_load)
        else $error("result loaded over a pending transaction");

endmodule

FILE: rtl/directed_graph_cycle_detect.sv
// Directed graph cycle detector. Each slave transaction carries an operation in
// s_tuser: add the edge from_vertex -> to_vertex, clear all edges, or check the graph.
// Adds and clears are accepted back to back; an edge with an endpoint at or above the
// active vertex count (cfg_wr_data, saturated at VERTICES) is dropped, and the clear takes
// effect at once through per-row valid bits, with no sweep.
// A check runs a depth-first search with an explicit frame stack and holds s_tready low
// until its single result (has_cycle) is loaded into the master-side output register.
// The search tests one adjacency bit per cycle from a registered row, pausing at each set
// bit to read its target's mark. A check steps through each start vertex, the bits of each
// visited vertex's row, a mark read for each edge met, a return to each parent frame, and
// the accepting and reporting of the result, plus any wait for the master side to free the
// output register. Operation code 3 is ignored.
module directed_graph_cycle_detect #(
    parameter int VERTICES = dgcd_pkg::DEF_VERTICES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: vertex count
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // Slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] from_vertex, [11:6] to_vertex, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] has_cycle, [7:1] zero
);
    import dgcd_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic has_cycle;

    dgcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    dgcd_datapath #(
        .VERTICES (VERTICES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_from     (s_tdata[5:0]),
        .in_to       (s_tdata[11:6]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_has_cycle (has_cycle)
    );

    assign m_tdata = {7'b0, has_cycle};

endmodule

FILE: tb/sv/tb_directed_graph_cycle_detect.sv
`timescale 1ns / 100ps

module tb_directed_graph_cycle_detect;
    import dgcd_pkg::*;

    localparam int VERTS           = DEF_VERTICES;
    localparam int ITEM_TARGET     = 1650;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = VERTS * VERTS + 6 * VERTS + 16;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int TIMEOUT_CYCLES  = 4 * (ITEM_TARGET + 400) *
                                     (2 * VERTS * VERTS + 8 * VERTS + 64);
    localparam int PHASE_COUNT     = 17;

    typedef struct packed {
        op_t                       op;
        logic [VERTEX_FIELD_W-1:0] from_v;
        logic [VERTEX_FIELD_W-1:0] to_v;
    } graph_cmd_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;   // [5:0] from_vertex, [11:6] to_vertex, [15:12] zero
    logic [1:0]  s_tuser     = '0;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;            // [0] has_cycle, [7:1] zero

    // Predictor state: the adjacency matrix and the vertex count as last written.
    logic [VERTS-1:0] edge_matrix [VERTS];
    int unsigned      vertex_count_cfg = VCOUNT_RESET;

    graph_cmd_t  pending_cmds [$];
    bit          expected_cycle_flags [$];
    graph_cmd_t  cur_cmd;
    int unsigned send_gap, send_calm, ready_gap, recv_calm, hold_left;
    int unsigned results_seen, mismatch_count, phase_items, total_items, timeout_cycles;
    bit          want_cycle, start_hold;

    directed_graph_cycle_detect #(
        .VERTICES(VERTS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned active_vertices();
        return (vertex_count_cfg > VERTS) ? VERTS : vertex_count_cfg;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Depth-first search with three marks per vertex and an explicit frame stack.
    function automatic bit graph_has_cycle();
        mark_t       marks [VERTS];
        int unsigned path [VERTS];
        int unsigned cursor [VERTS];
        int unsigned n, depth, v, w;
        n = active_vertices();
        foreach (marks[i]) marks[i] = MARK_NEW;
        for (int unsigned s = 0; s < n; s++) begin
            if (marks[s] != MARK_NEW) continue;
            path[0]   = s;
            cursor[0] = 0;
            depth     = 1;
            marks[s]  = MARK_PATH;
            while (depth > 0) begin
                v = path[depth-1];
                w = cursor[depth-1];
                while (w < n && !edge_matrix[v][w]) w++;
                if (w >= n) begin
                    marks[v] = MARK_DONE;
                    depth--;
                end else begin
                    cursor[depth-1] = w + 1;
                    if (marks[w] == MARK_PATH) return 1'b1;
                    if (marks[w] == MARK_NEW) begin
                        path[depth]   = w;
                        cursor[depth] = 0;
                        depth++;
                        marks[w] = MARK_PATH;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Update the predicted graph for one accepted transaction.
    function automatic void apply_cmd(graph_cmd_t c);
        int unsigned n;
        n = active_vertices();
        case (c.op)
            OP_ADD_EDGE: begin
                if (c.from_v < n && c.to_v < n) edge_matrix[c.from_v][c.to_v] = 1'b1;
            end
            OP_CLEAR_EDGES: begin
                foreach (edge_matrix[r]) edge_matrix[r] = '0;
            end
            OP_CHECK: begin
                expected_cycle_flags.push_back(graph_has_cycle());
            end
            default: ;
        endcase
    endfunction

    // Slave-side driver: presents queued commands with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap  = 0;
            send_calm = 0;
            foreach (edge_matrix[r]) edge_matrix[r] = '0;
        end else begin
            if (s_tvalid && s_tready) apply_cmd(cur_cmd);
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tdata  <= {4'b0000, cur_cmd.to_v, cur_cmd.from_v};
                    s_tuser  <= cur_cmd.op;
                    s_tvalid <= 1'b1;
                    if (send_calm != 0) send_calm--;
                    else if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 80);
                    send_gap = (send_calm != 0) ? 0 : draw_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master-side monitor: checks each result and throttles m_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_gap = 0;
            recv_calm = 0;
            hold_left = 0;
        end else begin
            start_hold = 1'b0;
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_cycle_flags.size() == 0) begin
                    $error("has_cycle: expected no transaction, actual %0d", m_tdata[0]);
                    mismatch_count++;
                end else begin
                    want_cycle = expected_cycle_flags.pop_front();
                    if (m_tdata[0] !== want_cycle) begin
                        $error("has_cycle: expected %0d, actual %0d", want_cycle, m_tdata[0]);
                        mismatch_count++;
                    end
                end
                // A long hold-off lets a finished check back up into the input.
                start_hold = (results_seen == 3 || results_seen == 60);
            end
            if (start_hold) begin
                hold_left = HOLD_OFF_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (ready_gap != 0) begin
                ready_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_calm != 0) recv_calm--;
                else if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(30, 80);
                if (recv_calm == 0 && $urandom_range(0, 3) == 0) ready_gap = draw_gap();
            end
        end
    end

    initial begin
        timeout_cycles = 0;
        while (timeout_cycles < TIMEOUT_CYCLES) begin
            @(posedge aclk);
            timeout_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Every queued transaction counts towards the item budget.
    task automatic queue_cmd(input op_t op, input int unsigned from_v, input int unsigned to_v);
        graph_cmd_t  c;
        c.op     = op;
        c.from_v = from_v[VERTEX_FIELD_W-1:0];
        c.to_v   = to_v[VERTEX_FIELD_W-1:0];
        pending_cmds.push_back(c);
        phase_items++;
        total_items++;
    endtask

    // Clear, load a random acyclic graph, perhaps close a cycle, then check.
    task automatic queue_sequence();
        int unsigned n, k, a, b, c;
        n = active_vertices();
        queue_cmd(OP_CLEAR_EDGES, $urandom_range(0, 63), $urandom_range(0, 63));
        k = (n < 8) ? $urandom_range(0, 2 * n) : $urandom_range(0, 16);
        repeat (k) begin
            if (n < VERTS && $urandom_range(0, 5) == 0) begin
                a = $urandom_range(n, VERTS - 1);
                b = $urandom_range(0, VERTS - 1);
                if ($urandom_range(0, 1) == 0) queue_cmd(OP_ADD_EDGE, a, b);
                else queue_cmd(OP_ADD_EDGE, b, a);
            end else if (n >= 2) begin
                a = $urandom_range(0, n - 2);
                b = $urandom_range(a + 1, n - 1);
                queue_cmd(OP_ADD_EDGE, a, b);
            end
        end
        case ($urandom_range(0, 3))
            1: begin
                if (n >= 1) begin
                    a = $urandom_range(0, n - 1);
                    queue_cmd(OP_ADD_EDGE, a, a);
                end
            end
            2: begin
                if (n >= 3) begin
                    a = $urandom_range(0, n - 3);
                    b = $urandom_range(a + 1, n - 2);
                    c = $urandom_range(b + 1, n - 1);
                    queue_cmd(OP_ADD_EDGE, a, b);
                    queue_cmd(OP_ADD_EDGE, b, c);
                    queue_cmd(OP_ADD_EDGE, c, a);
                end
            end
            3: begin
                if (n >= 2) begin
                    a = $urandom_range(0, n - 2);
                    b = $urandom_range(a + 1, n - 1);
                    queue_cmd(OP_ADD_EDGE, b, a);
                end
            end
            default: ;
        endcase
        queue_cmd(OP_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
        // Sometimes add a back edge to the same graph and check again.
        if (n >= 2 && $urandom_range(0, 3) == 0) begin
            b = $urandom_range(1, n - 1);
            a = $urandom_range(0, b - 1);
            queue_cmd(OP_ADD_EDGE, b, a);
            queue_cmd(OP_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    // The first check runs on whatever the previous phase left behind.
    task automatic queue_phase(input int unsigned budget);
        phase_items = 0;
        queue_cmd(OP_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
        while (phase_items < budget) begin
            if ($urandom_range(0, 99) < 20)
                queue_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                          $urandom_range(0, 63));
            else
                queue_sequence();
        end
    endtask

    // Sampled on the falling edge so the driver has settled for this cycle.
    task automatic wait_idle(input int unsigned settle);
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_cycle_flags.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input int unsigned value);
        wait_idle(SETTLE_CYCLES);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[COUNT_FIELD_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        vertex_count_cfg = value;
    endtask

    initial begin
        int unsigned phase_counts [PHASE_COUNT];
        int unsigned p;
        phase_counts = '{3, 9, 127, 5, 16, 1, 64, 12, 0, 2, 24, 7, 40, 6, 100, 10, 4};
        total_items = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset count: empty graph, unused op, cycle between the end vertices.
        queue_cmd(OP_CHECK, 0, 0);
        queue_cmd(OP_UNUSED, 63, 63);
        queue_cmd(OP_ADD_EDGE, 63, 0);
        queue_cmd(OP_ADD_EDGE, 0, 63);
        queue_cmd(OP_CHECK, 63, 63);
        queue_cmd(OP_CLEAR_EDGES, 63, 63);
        queue_cmd(OP_CHECK, 0, 0);
        // A self-loop on its own.
        queue_cmd(OP_ADD_EDGE, 5, 5);
        queue_cmd(OP_CHECK, 0, 0);
        // Triangle of forward edges with a duplicate edge is acyclic; a back edge closes it.
        queue_cmd(OP_CLEAR_EDGES, 0, 0);
        queue_cmd(OP_ADD_EDGE, 0, 1);
        queue_cmd(OP_ADD_EDGE, 1, 2);
        queue_cmd(OP_ADD_EDGE, 0, 2);
        queue_cmd(OP_ADD_EDGE, 0, 1);
        queue_cmd(OP_CHECK, 0, 0);
        queue_cmd(OP_ADD_EDGE, 2, 0);
        queue_cmd(OP_CHECK, 0, 0);
        queue_cmd(OP_CLEAR_EDGES, 0, 0);
        queue_cmd(OP_ADD_EDGE, 10, 20);
        queue_cmd(OP_ADD_EDGE, 20, 30);
        queue_cmd(OP_ADD_EDGE, 30, 10);
        queue_cmd(OP_CHECK, 0, 0);

        // Shrunk count hides the stored cycle; out-of-range adds are dropped.
        write_vertex_count(12);
        queue_cmd(OP_CHECK, 0, 0);
        queue_cmd(OP_ADD_EDGE, 2, 40);
        queue_cmd(OP_ADD_EDGE, 40, 2);
        queue_cmd(OP_CHECK, 0, 0);
        // Zero vertices: nothing to search and nothing can be added.
        write_vertex_count(0);
        queue_cmd(OP_ADD_EDGE, 0, 0);
        queue_cmd(OP_CHECK, 0, 0);
        // Count above the store size saturates; the hidden cycle is visible again.
        write_vertex_count(127);
        queue_cmd(OP_CHECK, 0, 0);

        // Random phases, cycling through a range of vertex counts.
        p = 0;
        while (total_items < ITEM_TARGET) begin
            write_vertex_count(phase_counts[p]);
            queue_phase((active_vertices() >= 32) ? 40 : 130);
            p = (p + 1) % PHASE_COUNT;
        end

        wait_idle(DRAIN_CYCLES);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
